/* src/espc_pkg.sv */
// ============================================================================
// espc_pkg: shared types and constants of the socket policy classifier
// Request codes, verdict codes, register indexes, mode flag positions and
// the write request that the pipeline hands to the bypass prefix table.
// ============================================================================
package espc_pkg;

    typedef enum logic [2:0] {
        REQ_CONNECT4    = 3'd0,
        REQ_SOCK_CREATE = 3'd1,
        REQ_SENDMSG4    = 3'd2,
        REQ_CONNECT6    = 3'd3,
        REQ_SENDMSG6    = 3'd4,
        REQ_BYPASS_WR   = 3'd5
    } req_type_t;

    typedef enum logic [1:0] {
        VERDICT_DENY     = 2'd0,
        VERDICT_ALLOW    = 2'd1,
        VERDICT_REDIRECT = 2'd2
    } verdict_t;

    typedef enum logic [2:0] {
        REG_RELAY_UID     = 3'd0,
        REG_REDIRECT_IP4  = 3'd1,
        REG_REDIRECT_PORT = 3'd2,
        REG_DNS_IP4       = 3'd3,
        REG_DNS_SRV_PORT  = 3'd4,
        REG_MODE_FLAGS    = 3'd5
    } cfg_reg_t;

    // Bit positions inside mode_flags.
    localparam int FLAG_CAPTURE  = 0;
    localparam int FLAG_TCP_ONLY = 1;
    localparam int FLAG_NO_IPV6  = 2;

    localparam logic [7:0] PROTO_TCP      = 8'd6;
    localparam logic [7:0] PROTO_UDP      = 8'd17;
    localparam logic [3:0] TYPE_STREAM    = 4'd1;
    localparam logic [3:0] TYPE_DGRAM     = 4'd2;
    localparam logic [7:0] LOOPBACK_NET   = 8'd127;
    localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

    // One write into the bypass prefix table.
    typedef struct packed {
        logic        en;
        logic        install;
        logic [5:0]  idx;
        logic [31:0] addr;
        logic [5:0]  len;
    } bypass_wr_t;

    // Network mask for a prefix length of 0 to 32 bits.
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        prefix_mask = ~(32'hffff_ffff >> len);
    endfunction

endpackage

/* src/espc_bypass_tbl.sv */
// ============================================================================
// espc_bypass_tbl: bypass prefix table
// Holds the bypass prefixes and compares one address against every valid
// slot at once; a write from the pipeline installs or clears one slot.
// ============================================================================
module espc_bypass_tbl #(
    parameter int ENTRIES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  espc_pkg::bypass_wr_t wr,
    input  logic [31:0]          lookup_ip4,
    output logic                 hit
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic [31:0]        addr_reg  [ENTRIES];
    logic [5:0]         len_reg   [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] match;
    logic [IW-1:0]      wr_slot;
    logic               wr_in_range;
    logic               wr_len_ok;

    assign wr_slot     = IW'(wr.idx);
    assign wr_in_range = (9'(wr.idx) < 9'(ENTRIES));
    assign wr_len_ok   = (wr.len <= espc_pkg::MAX_PREFIX_LEN);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en && wr_in_range) begin
            if (!wr.install) begin
                valid_reg[wr_slot] <= 1'b0;
            end else if (wr_len_ok) begin
                valid_reg[wr_slot] <= 1'b1;
            end
        end
    end

    // Prefix contents are only read behind their valid bit.
    always_ff @(posedge aclk) begin
        if (wr.en && wr_in_range && wr.install && wr_len_ok) begin
            addr_reg[wr_slot] <= wr.addr;
            len_reg[wr_slot]  <= wr.len;
        end
    end

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = valid_reg[i] &&
                (((lookup_ip4 ^ addr_reg[i]) & espc_pkg::prefix_mask(len_reg[i])) == 32'd0);
        end
    end

    assign hit = |match;

    a_clear_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && wr_in_range && !wr.install) |=> !valid_reg[$past(wr_slot)])
        else $error("cleared bypass slot is still valid");

    a_install_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && wr_in_range && wr.install && wr_len_ok) |=> valid_reg[$past(wr_slot)])
        else $error("installed bypass slot is not valid");

    a_bad_len_ignored: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && wr_in_range && wr.install && !wr_len_ok)
            |=> (valid_reg[$past(wr_slot)] == $past(valid_reg[wr_slot])))
        else $error("over-long prefix changed a bypass slot");

endmodule

/* src/egress_socket_policy_classifier.sv */
// ============================================================================
// egress_socket_policy_classifier: socket event policy engine
// Gives an allow, deny or redirect verdict for each socket event and keeps
// the bypass prefix table that captured IPv4 TCP connects are checked against.
// ============================================================================
//
//  channel   direction  handshake                        contents
//  s_*       in         s_valid / s_ready                one socket event item
//  m_*       out        m_valid / m_ready                one verdict item
//  APB       in/out     psel, penable, pwrite, pready    six config registers
//
// Each item first sits in the input register, where the verdict and the
// bypass prefix compare are worked out, and then sits in the result register.
// A new item can be accepted every cycle while m_ready is high.
// Reset (aresetn low at a clock edge) empties both registers, zeroes the
// configuration registers and invalidates every bypass slot.
// When m_ready is low and both registers are full, s_ready drops; nothing is
// lost or repeated. A bypass write changes the table as its item leaves the
// input register, so every later item sees it and no earlier one does.
//
// Register map (byte addresses): 0x00 relay_uid, 0x04 redirect_ip4,
// 0x08 redirect_port, 0x0c dns_ip4, 0x10 dns_srv_port, 0x14 mode_flags.
// ============================================================================
module egress_socket_policy_classifier #(
    parameter int BYPASS_ENTRIES = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Event items in
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_req_type,
    input  logic [31:0] s_caller_uid,
    input  logic [7:0]  s_protocol,
    input  logic [3:0]  s_sock_type,
    input  logic [31:0] s_dst_ip4,
    input  logic [15:0] s_dst_port,
    input  logic        s_record_store_ok,
    input  logic [5:0]  s_entry_index,
    input  logic [31:0] s_entry_addr,
    input  logic [5:0]  s_entry_prefix_len,
    input  logic        s_entry_valid,

    // Verdict items out
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_verdict,
    output logic [31:0] m_new_dst_ip4,
    output logic [15:0] m_new_dst_port,
    output logic        m_record_valid,
    output logic [31:0] m_record_ip4,
    output logic [15:0] m_record_port,
    output logic [31:0] m_record_uid
);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [31:0] relay_uid_reg;
    logic [31:0] redirect_ip4_reg;
    logic [15:0] redirect_port_reg;
    logic [31:0] dns_ip4_reg;
    logic [15:0] dns_srv_port_reg;
    logic [2:0]  mode_flags_reg;

    logic               cfg_wr;
    espc_pkg::cfg_reg_t cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = espc_pkg::cfg_reg_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relay_uid_reg     <= '0;
            redirect_ip4_reg  <= '0;
            redirect_port_reg <= '0;
            dns_ip4_reg       <= '0;
            dns_srv_port_reg  <= '0;
            mode_flags_reg    <= '0;
        end else if (cfg_wr) begin
            case (cfg_sel)
                espc_pkg::REG_RELAY_UID:     relay_uid_reg     <= pwdata;
                espc_pkg::REG_REDIRECT_IP4:  redirect_ip4_reg  <= pwdata;
                espc_pkg::REG_REDIRECT_PORT: redirect_port_reg <= pwdata[15:0];
                espc_pkg::REG_DNS_IP4:       dns_ip4_reg       <= pwdata;
                espc_pkg::REG_DNS_SRV_PORT:  dns_srv_port_reg  <= pwdata[15:0];
                espc_pkg::REG_MODE_FLAGS:    mode_flags_reg    <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_sel)
            espc_pkg::REG_RELAY_UID:     prdata = relay_uid_reg;
            espc_pkg::REG_REDIRECT_IP4:  prdata = redirect_ip4_reg;
            espc_pkg::REG_REDIRECT_PORT: prdata = {16'd0, redirect_port_reg};
            espc_pkg::REG_DNS_IP4:       prdata = dns_ip4_reg;
            espc_pkg::REG_DNS_SRV_PORT:  prdata = {16'd0, dns_srv_port_reg};
            espc_pkg::REG_MODE_FLAGS:    prdata = {29'd0, mode_flags_reg};
            default:                     prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------------
    logic        in_valid_reg;
    logic [2:0]  req_type_reg;
    logic [31:0] caller_uid_reg;
    logic [7:0]  protocol_reg;
    logic [3:0]  sock_type_reg;
    logic [31:0] dst_ip4_reg;
    logic [15:0] dst_port_reg;
    logic        store_ok_reg;
    logic [5:0]  entry_index_reg;
    logic [31:0] entry_addr_reg;
    logic [5:0]  entry_len_reg;
    logic        entry_valid_reg;

    logic out_valid_reg;
    logic advance;     // the item in the input register moves to the result register

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg    <= s_req_type;
            caller_uid_reg  <= s_caller_uid;
            protocol_reg    <= s_protocol;
            sock_type_reg   <= s_sock_type;
            dst_ip4_reg     <= s_dst_ip4;
            dst_port_reg    <= s_dst_port;
            store_ok_reg    <= s_record_store_ok;
            entry_index_reg <= s_entry_index;
            entry_addr_reg  <= s_entry_addr;
            entry_len_reg   <= s_entry_prefix_len;
            entry_valid_reg <= s_entry_valid;
        end
    end

    // ---------------------------------------------------------------------
    // Bypass prefix table
    // ---------------------------------------------------------------------
    espc_pkg::bypass_wr_t bypass_wr;
    logic                 bypass_hit;
    espc_pkg::req_type_t  req;

    assign req = espc_pkg::req_type_t'(req_type_reg);

    assign bypass_wr.en      = advance && (req == espc_pkg::REQ_BYPASS_WR);
    assign bypass_wr.install = entry_valid_reg;
    assign bypass_wr.idx     = entry_index_reg;
    assign bypass_wr.addr    = entry_addr_reg;
    assign bypass_wr.len     = entry_len_reg;

    espc_bypass_tbl #(
        .ENTRIES (BYPASS_ENTRIES)
    ) u_bypass_tbl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (bypass_wr),
        .lookup_ip4 (dst_ip4_reg),
        .hit        (bypass_hit)
    );

    // ---------------------------------------------------------------------
    // Verdict
    // ---------------------------------------------------------------------
    logic is_proxy;
    logic dns_ok;
    logic datagram_ok;
    logic redirect;
    espc_pkg::verdict_t verdict;

    assign is_proxy = (caller_uid_reg == relay_uid_reg);
    // The DNS exception is off while no DNS address is configured.
    assign dns_ok   = (dns_ip4_reg != 32'd0) && (dst_ip4_reg == dns_ip4_reg) &&
                      (dst_port_reg == dns_srv_port_reg);
    // Shared by IPv4 sends and non-TCP IPv4 connects.
    assign datagram_ok = !mode_flags_reg[espc_pkg::FLAG_TCP_ONLY] || is_proxy || dns_ok;

    always_comb begin
        verdict  = espc_pkg::VERDICT_DENY;
        redirect = 1'b0;
        case (req)
            espc_pkg::REQ_CONNECT4: begin
                if (protocol_reg != espc_pkg::PROTO_TCP) begin
                    verdict = datagram_ok ? espc_pkg::VERDICT_ALLOW : espc_pkg::VERDICT_DENY;
                end else if (!mode_flags_reg[espc_pkg::FLAG_CAPTURE] || is_proxy ||
                             (dst_ip4_reg[31:24] == espc_pkg::LOOPBACK_NET) ||
                             dns_ok || bypass_hit) begin
                    verdict = espc_pkg::VERDICT_ALLOW;
                end else if (!store_ok_reg) begin
                    verdict = espc_pkg::VERDICT_DENY;
                end else begin
                    verdict  = espc_pkg::VERDICT_REDIRECT;
                    redirect = 1'b1;
                end
            end
            espc_pkg::REQ_SOCK_CREATE: begin
                if (!mode_flags_reg[espc_pkg::FLAG_TCP_ONLY] || is_proxy ||
                    (sock_type_reg == espc_pkg::TYPE_STREAM &&
                     protocol_reg == espc_pkg::PROTO_TCP) ||
                    (sock_type_reg == espc_pkg::TYPE_DGRAM &&
                     protocol_reg == espc_pkg::PROTO_UDP)) begin
                    verdict = espc_pkg::VERDICT_ALLOW;
                end
            end
            espc_pkg::REQ_SENDMSG4: begin
                verdict = datagram_ok ? espc_pkg::VERDICT_ALLOW : espc_pkg::VERDICT_DENY;
            end
            espc_pkg::REQ_CONNECT6: begin
                if (!mode_flags_reg[espc_pkg::FLAG_NO_IPV6] || is_proxy) begin
                    verdict = espc_pkg::VERDICT_ALLOW;
                end
            end
            espc_pkg::REQ_SENDMSG6: begin
                if ((!mode_flags_reg[espc_pkg::FLAG_TCP_ONLY] &&
                     !mode_flags_reg[espc_pkg::FLAG_NO_IPV6]) || is_proxy) begin
                    verdict = espc_pkg::VERDICT_ALLOW;
                end
            end
            espc_pkg::REQ_BYPASS_WR: begin
                verdict = espc_pkg::VERDICT_ALLOW;
            end
            default: begin
                verdict = espc_pkg::VERDICT_DENY;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    logic [1:0]  verdict_reg,       verdict_next;
    logic [31:0] new_dst_ip4_reg,   new_dst_ip4_next;
    logic [15:0] new_dst_port_reg,  new_dst_port_next;
    logic        record_valid_reg,  record_valid_next;
    logic [31:0] record_ip4_reg,    record_ip4_next;
    logic [15:0] record_port_reg,   record_port_next;
    logic [31:0] record_uid_reg,    record_uid_next;

    // Outside a redirect the destination is echoed and the record is zero.
    always_comb begin
        verdict_next      = verdict;
        new_dst_ip4_next  = redirect ? redirect_ip4_reg  : dst_ip4_reg;
        new_dst_port_next = redirect ? redirect_port_reg : dst_port_reg;
        record_valid_next = redirect;
        record_ip4_next   = redirect ? dst_ip4_reg    : 32'd0;
        record_port_next  = redirect ? dst_port_reg   : 16'd0;
        record_uid_next   = redirect ? caller_uid_reg : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            verdict_reg      <= verdict_next;
            new_dst_ip4_reg  <= new_dst_ip4_next;
            new_dst_port_reg <= new_dst_port_next;
            record_valid_reg <= record_valid_next;
            record_ip4_reg   <= record_ip4_next;
            record_port_reg  <= record_port_next;
            record_uid_reg   <= record_uid_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_verdict      = verdict_reg;
    assign m_new_dst_ip4  = new_dst_ip4_reg;
    assign m_new_dst_port = new_dst_port_reg;
    assign m_record_valid = record_valid_reg;
    assign m_record_ip4   = record_ip4_reg;
    assign m_record_port  = record_port_reg;
    assign m_record_uid   = record_uid_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_record_iff_redirect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_record_valid == (m_verdict == espc_pkg::VERDICT_REDIRECT)))
        else $error("record flag disagrees with redirect verdict");

    a_record_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_record_valid) |->
            (m_record_ip4 == 32'd0 && m_record_port == 16'd0 && m_record_uid == 32'd0))
        else $error("record fields set without a record");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("item accepted while both registers are held");

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted item did not reach the input register");

endmodule
